/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/siqrr_pkg.sv */
package siqrr_pkg;

    localparam int NUM_LEVELS = 6;
    localparam int NUM_RELAYS = 4;

    // debounced level slots
    localparam int LVL_READY    = 0;
    localparam int LVL_RUN      = 1;
    localparam int LVL_SPARE    = 2;
    localparam int LVL_RESET    = 3;
    localparam int LVL_LOCAL    = 4;
    localparam int LVL_FEEDBACK = 5;

    localparam logic [3:0] LVL_LIMIT [NUM_LEVELS] = '{4'd5, 4'd10, 4'd5, 4'd5, 4'd5, 4'd2};

    localparam logic [3:0] PRESS_LIMIT      = 4'd10;
    localparam logic [3:0] SINGLE_LIMIT     = 4'd5;
    localparam logic [3:0] START_HOLD_LIMIT = 4'd5;
    localparam logic [3:0] STOP_HOLD_LIMIT  = 4'd10;
    localparam logic [4:0] PULSE_LIMIT      = 5'd20;

    localparam logic [7:0] STEP_START   = 8'd1;
    localparam logic [7:0] STEP_STOP_LO = 8'd3;
    localparam logic [7:0] STEP_STOP_HI = 8'd10;

    // configuration register indexes
    localparam logic [2:0] CFG_SINGLE_MODE = 3'd0;
    localparam logic [2:0] CFG_RESET_EN    = 3'd1;
    localparam logic [2:0] CFG_RELAY_A     = 3'd2;
    localparam logic [2:0] CFG_RELAY_B     = 3'd3;
    localparam logic [2:0] CFG_RELAY_C     = 3'd4;
    localparam logic [2:0] CFG_RELAY_D     = 3'd5;

    typedef struct packed {
        logic                  start_pin;
        logic                  stop_pin;
        logic [NUM_LEVELS-1:0] level_pins;
        logic [7:0]            sequence_step;
        logic [3:0]            relay_sources;
        logic                  close_pulse_request;
        logic                  open_pulse_request;
    } in_item_t;

endpackage

/* rtl/starter_input_qualifier_relay_router.sv */
// an accepted item's result is registered in the output register; throughput: one
// item per cycle while out_stall is low; an item sits in the input register while
// the result register drains, and all per-tick work is one pass between the two
// reset (rst_n low, asynchronous): all counters, flags, relay levels and
// configuration registers clear to zero, and both item registers are empty
`include "assert_macros.svh"

module starter_input_qualifier_relay_router
    import siqrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [2:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       start_pin,
    input  logic       stop_pin,
    input  logic       ready_pin,
    input  logic       run_check_pin,
    input  logic       spare_pin,
    input  logic       reset_pin,
    input  logic       local_remote_pin,
    input  logic       contactor_feedback_pin,
    input  logic [7:0] sequence_step,
    input  logic [3:0] relay_sources,
    input  logic       close_pulse_request,
    input  logic       open_pulse_request,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       start_command,
    output logic       stop_command,
    output logic       ready_level,
    output logic       run_check_level,
    output logic       spare_level,
    output logic       reset_command,
    output logic       local_remote_level,
    output logic       contactor_feedback_level,
    output logic       relay_a,
    output logic       relay_b,
    output logic       relay_c,
    output logic       relay_d
);

    // configuration
    logic       single_mode_reg;
    logic       reset_en_reg;
    logic [2:0] relay_sel_reg [NUM_RELAYS];

    // item registers
    logic     in_valid_reg;
    in_item_t item_reg;
    logic     out_valid_reg;
    logic     advance;

    // tick state
    logic [3:0] start_press_reg, start_press_next;
    logic [3:0] stop_press_reg, stop_press_next;
    logic [3:0] single_start_reg, single_start_next;
    logic [3:0] single_stop_reg, single_stop_next;
    logic [3:0] single_start_hold_reg, single_start_hold_next;
    logic [3:0] single_stop_hold_reg, single_stop_hold_next;
    logic [3:0] start_hold_reg, start_hold_next;
    logic [3:0] stop_hold_reg, stop_hold_next;
    logic [3:0] lvl_low_reg [NUM_LEVELS];
    logic [3:0] lvl_low_next [NUM_LEVELS];
    logic [3:0] lvl_high_reg [NUM_LEVELS];
    logic [3:0] lvl_high_next [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] lvl_flag_reg, lvl_flag_next;
    logic start_flag_reg, start_flag_next;
    logic stop_flag_reg, stop_flag_next;
    logic close_flag_reg, close_flag_next;
    logic open_flag_reg, open_flag_next;
    logic [4:0] close_cnt_reg, close_cnt_next;
    logic [4:0] open_cnt_reg, open_cnt_next;
    logic [NUM_RELAYS-1:0] relay_reg, relay_next;

    logic       start_low;
    logic       stop_low;
    logic       src_ready;
    logic       src_start;
    logic       src_alarm;
    logic       src_trip;
    logic       run_now;
    logic [7:0] relay_src [NUM_RELAYS];
    logic       ready_saturated;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_mode_reg <= 1'b0;
            reset_en_reg    <= 1'b0;
            for (int r = 0; r < NUM_RELAYS; r++)
            begin
                relay_sel_reg[r] <= 3'd0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SINGLE_MODE: single_mode_reg  <= cfg_data[0];
                CFG_RESET_EN:    reset_en_reg     <= cfg_data[0];
                CFG_RELAY_A:     relay_sel_reg[0] <= cfg_data;
                CFG_RELAY_B:     relay_sel_reg[1] <= cfg_data;
                CFG_RELAY_C:     relay_sel_reg[2] <= cfg_data;
                CFG_RELAY_D:     relay_sel_reg[3] <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.start_pin           <= start_pin;
            item_reg.stop_pin            <= stop_pin;
            item_reg.level_pins          <= {contactor_feedback_pin, local_remote_pin, reset_pin,
                                             spare_pin, run_check_pin, ready_pin};
            item_reg.sequence_step       <= sequence_step;
            item_reg.relay_sources       <= relay_sources;
            item_reg.close_pulse_request <= close_pulse_request;
            item_reg.open_pulse_request  <= open_pulse_request;
        end
    end

    // one tick of the qualifier
    always_comb
    begin
        start_press_next       = start_press_reg;
        stop_press_next        = stop_press_reg;
        single_start_next      = single_start_reg;
        single_stop_next       = single_stop_reg;
        single_start_hold_next = single_start_hold_reg;
        single_stop_hold_next  = single_stop_hold_reg;
        start_hold_next        = start_hold_reg;
        stop_hold_next         = stop_hold_reg;
        lvl_low_next           = lvl_low_reg;
        lvl_high_next          = lvl_high_reg;
        lvl_flag_next          = lvl_flag_reg;
        start_flag_next        = start_flag_reg;
        stop_flag_next         = stop_flag_reg;
        close_flag_next        = close_flag_reg | item_reg.close_pulse_request;
        open_flag_next         = open_flag_reg | item_reg.open_pulse_request;
        close_cnt_next         = close_cnt_reg;
        open_cnt_next          = open_cnt_reg;

        start_low = !item_reg.start_pin;
        stop_low  = !item_reg.stop_pin;

        if (!single_mode_reg)
        begin
            if (start_low)
            begin
                start_hold_next  = 4'd0;
                start_press_next = start_press_next + 4'd1;
                if (start_press_next > PRESS_LIMIT)
                begin
                    start_press_next = 4'd0;
                    start_flag_next  = 1'b1;
                    stop_flag_next   = 1'b0;
                end
            end
            else
            begin
                start_press_next = 4'd0;
            end
            if (stop_low)
            begin
                stop_hold_next  = 4'd0;
                stop_press_next = stop_press_next + 4'd1;
                if (stop_press_next > PRESS_LIMIT)
                begin
                    stop_press_next = 4'd0;
                    stop_flag_next  = 1'b1;
                    start_flag_next = 1'b0;
                end
            end
            else
            begin
                stop_press_next = 4'd0;
            end
        end
        else
        begin
            if (start_low && item_reg.sequence_step == STEP_START)
            begin
                single_start_next = single_start_next + 4'd1;
                if (single_start_next > SINGLE_LIMIT)
                begin
                    single_start_next = 4'd0;
                    start_flag_next   = 1'b1;
                    stop_flag_next    = 1'b0;
                end
            end
            else
            begin
                single_start_next = 4'd0;
            end
            if (!start_low && item_reg.sequence_step >= STEP_STOP_LO &&
                item_reg.sequence_step <= STEP_STOP_HI)
            begin
                single_stop_next = single_stop_next + 4'd1;
                if (single_stop_next > SINGLE_LIMIT)
                begin
                    single_stop_next = 4'd0;
                    stop_flag_next   = 1'b1;
                    start_flag_next  = 1'b0;
                end
            end
            else
            begin
                single_stop_next = 4'd0;
            end
            if (start_flag_next)
            begin
                single_start_next      = 4'd0;
                single_start_hold_next = single_start_hold_next + 4'd1;
                if (single_start_hold_next > SINGLE_LIMIT)
                begin
                    single_start_hold_next = 4'd0;
                    start_flag_next        = 1'b0;
                end
            end
            if (stop_flag_next)
            begin
                single_stop_next      = 4'd0;
                single_stop_hold_next = single_stop_hold_next + 4'd1;
                if (single_stop_hold_next > SINGLE_LIMIT)
                begin
                    single_stop_hold_next = 4'd0;
                    stop_flag_next        = 1'b0;
                end
            end
        end

        // pulse self-clear
        if (start_flag_next)
        begin
            start_press_next = 4'd0;
            start_hold_next  = start_hold_next + 4'd1;
            if (start_hold_next > START_HOLD_LIMIT)
            begin
                start_hold_next = 4'd0;
                start_flag_next = 1'b0;
            end
        end
        if (stop_flag_next)
        begin
            stop_press_next = 4'd0;
            stop_hold_next  = stop_hold_next + 4'd1;
            if (stop_hold_next > STOP_HOLD_LIMIT)
            begin
                stop_hold_next = 4'd0;
                stop_flag_next = 1'b0;
            end
        end

        // symmetric debounce, reset slot frozen unless enabled
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (i != LVL_RESET || reset_en_reg)
            begin
                if (!item_reg.level_pins[i])
                begin
                    lvl_high_next[i] = 4'd0;
                    lvl_low_next[i]  = lvl_low_reg[i] + 4'd1;
                    if (lvl_low_next[i] > LVL_LIMIT[i])
                    begin
                        lvl_low_next[i]  = LVL_LIMIT[i] + 4'd1;
                        lvl_flag_next[i] = 1'b1;
                    end
                end
                else
                begin
                    lvl_low_next[i]  = 4'd0;
                    lvl_high_next[i] = lvl_high_reg[i] + 4'd1;
                    if (lvl_high_next[i] > LVL_LIMIT[i])
                    begin
                        lvl_high_next[i] = LVL_LIMIT[i] + 4'd1;
                        lvl_flag_next[i] = 1'b0;
                    end
                end
            end
        end

        // stop wins
        if (stop_flag_next)
        begin
            start_flag_next = 1'b0;
        end

        // relay routing, top entry of each source list is the hold code
        src_ready = item_reg.relay_sources[0];
        src_start = item_reg.relay_sources[1];
        src_alarm = item_reg.relay_sources[2];
        src_trip  = item_reg.relay_sources[3];
        run_now   = lvl_flag_next[LVL_RUN];
        relay_src[0] = {relay_reg[0], open_flag_next, close_flag_next, src_trip, src_alarm,
                        run_now, src_start, src_ready};
        relay_src[1] = {relay_reg[1], open_flag_next, close_flag_next, src_trip, run_now,
                        src_start, src_ready, src_alarm};
        relay_src[2] = {relay_reg[2], open_flag_next, close_flag_next, src_alarm, run_now,
                        src_start, src_ready, src_trip};
        relay_src[3] = {relay_reg[3], open_flag_next, close_flag_next, src_trip, src_alarm,
                        src_start, src_ready, run_now};
        for (int r = 0; r < NUM_RELAYS; r++)
        begin
            relay_next[r] = relay_src[r][relay_sel_reg[r]];
        end

        // contactor pulse auto-clear
        if (close_flag_next)
        begin
            close_cnt_next = close_cnt_reg + 5'd1;
            if (close_cnt_next > PULSE_LIMIT)
            begin
                close_cnt_next  = 5'd0;
                close_flag_next = 1'b0;
            end
        end
        if (open_flag_next)
        begin
            open_cnt_next = open_cnt_reg + 5'd1;
            if (open_cnt_next > PULSE_LIMIT)
            begin
                open_cnt_next  = 5'd0;
                open_flag_next = 1'b0;
            end
        end
    end

    // tick state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_press_reg       <= 4'd0;
            stop_press_reg        <= 4'd0;
            single_start_reg      <= 4'd0;
            single_stop_reg       <= 4'd0;
            single_start_hold_reg <= 4'd0;
            single_stop_hold_reg  <= 4'd0;
            start_hold_reg        <= 4'd0;
            stop_hold_reg         <= 4'd0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                lvl_low_reg[i]  <= 4'd0;
                lvl_high_reg[i] <= 4'd0;
            end
            lvl_flag_reg   <= '0;
            start_flag_reg <= 1'b0;
            stop_flag_reg  <= 1'b0;
            close_flag_reg <= 1'b0;
            open_flag_reg  <= 1'b0;
            close_cnt_reg  <= 5'd0;
            open_cnt_reg   <= 5'd0;
            relay_reg      <= '0;
        end
        else if (advance)
        begin
            start_press_reg       <= start_press_next;
            stop_press_reg        <= stop_press_next;
            single_start_reg      <= single_start_next;
            single_stop_reg       <= single_stop_next;
            single_start_hold_reg <= single_start_hold_next;
            single_stop_hold_reg  <= single_stop_hold_next;
            start_hold_reg        <= start_hold_next;
            stop_hold_reg         <= stop_hold_next;
            lvl_low_reg           <= lvl_low_next;
            lvl_high_reg          <= lvl_high_next;
            lvl_flag_reg          <= lvl_flag_next;
            start_flag_reg        <= start_flag_next;
            stop_flag_reg         <= stop_flag_next;
            close_flag_reg        <= close_flag_next;
            open_flag_reg         <= open_flag_next;
            close_cnt_reg         <= close_cnt_next;
            open_cnt_reg          <= open_cnt_next;
            relay_reg             <= relay_next;
        end
    end

    assign out_valid                = out_valid_reg;
    assign start_command            = start_flag_reg;
    assign stop_command             = stop_flag_reg;
    assign ready_level              = lvl_flag_reg[LVL_READY];
    assign run_check_level          = lvl_flag_reg[LVL_RUN];
    assign spare_level              = lvl_flag_reg[LVL_SPARE];
    assign reset_command            = lvl_flag_reg[LVL_RESET];
    assign local_remote_level       = lvl_flag_reg[LVL_LOCAL];
    assign contactor_feedback_level = lvl_flag_reg[LVL_FEEDBACK];
    assign relay_a                  = relay_reg[0];
    assign relay_b                  = relay_reg[1];
    assign relay_c                  = relay_reg[2];
    assign relay_d                  = relay_reg[3];

    assign ready_saturated = (lvl_low_reg[LVL_READY] == LVL_LIMIT[LVL_READY] + 4'd1);

    `ASSERT_IMPL(a_stop_wins, stop_flag_reg, !start_flag_reg, "start and stop both set")
    `ASSERT_IMPL(a_close_cnt_flag, close_cnt_reg != 5'd0, close_flag_reg, "close count no flag")
    `ASSERT_NEXT(a_advance_result, advance, out_valid_reg, "item advanced but no result held")
    `ASSERT_IMPL(a_ready_rise, $rose(ready_level), ready_saturated, "ready rose too early")

endmodule

/* dv/starter_tick_scoreboard_pkg.sv */
`timescale 1ns / 100ps

package starter_tick_scoreboard_pkg;

    import siqrr_pkg::*;

    localparam logic [2:0] RELAY_HOLD = 3'd7;

    typedef struct packed {
        logic start_command;
        logic stop_command;
        logic ready_level;
        logic run_check_level;
        logic spare_level;
        logic reset_command;
        logic local_remote_level;
        logic contactor_feedback_level;
        logic relay_a;
        logic relay_b;
        logic relay_c;
        logic relay_d;
    } tick_out_t;

    class starter_tick_scoreboard;

        logic       single_mode = 1'b0;
        logic       reset_en = 1'b0;
        logic [2:0] relay_sel [NUM_RELAYS] = '{default: 3'd0};

        logic [3:0] start_press = '0;
        logic [3:0] stop_press = '0;
        logic [3:0] single_start_cnt = '0;
        logic [3:0] single_stop_cnt = '0;
        logic [3:0] single_start_hold = '0;
        logic [3:0] single_stop_hold = '0;
        logic [3:0] start_hold = '0;
        logic [3:0] stop_hold = '0;
        logic [3:0] low_cnt [NUM_LEVELS] = '{default: 4'd0};
        logic [3:0] high_cnt [NUM_LEVELS] = '{default: 4'd0};
        logic       level_flag [NUM_LEVELS] = '{default: 1'b0};
        logic       start_flag = 1'b0;
        logic       stop_flag = 1'b0;
        logic       close_flag = 1'b0;
        logic       open_flag = 1'b0;
        logic [4:0] close_cnt = '0;
        logic [4:0] open_cnt = '0;
        logic       relay_lv [NUM_RELAYS] = '{default: 1'b0};

        tick_out_t  expected_outputs [$];
        int         mismatches = 0;

        function new();
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        function void set_register(logic [2:0] idx, logic [2:0] val);
            case (idx)
                CFG_SINGLE_MODE: single_mode = val[0];
                CFG_RESET_EN:    reset_en = val[0];
                CFG_RELAY_A:     relay_sel[0] = val;
                CFG_RELAY_B:     relay_sel[1] = val;
                CFG_RELAY_C:     relay_sel[2] = val;
                CFG_RELAY_D:     relay_sel[3] = val;
                default: ;
            endcase
        endfunction

        function void settle_level(int i, logic asserted);
            if (asserted) begin
                high_cnt[i] = '0;
                low_cnt[i]++;
                if (low_cnt[i] > LVL_LIMIT[i]) begin
                    low_cnt[i] = LVL_LIMIT[i] + 4'd1;
                    level_flag[i] = 1'b1;
                end
            end
            else begin
                low_cnt[i] = '0;
                high_cnt[i]++;
                if (high_cnt[i] > LVL_LIMIT[i]) begin
                    high_cnt[i] = LVL_LIMIT[i] + 4'd1;
                    level_flag[i] = 1'b0;
                end
            end
        endfunction

        function void accept_tick(in_item_t t);
            logic       start_low;
            logic       stop_low;
            logic       rc;
            logic       ready_src;
            logic       start_src;
            logic       alarm_src;
            logic       trip_src;
            logic [6:0] choice [NUM_RELAYS];
            tick_out_t  want;

            start_low = !t.start_pin;
            stop_low = !t.stop_pin;
            if (t.close_pulse_request) close_flag = 1'b1;
            if (t.open_pulse_request) open_flag = 1'b1;

            if (!single_mode) begin
                if (start_low) begin
                    start_hold = '0;
                    start_press++;
                    if (start_press > PRESS_LIMIT) begin
                        start_press = '0;
                        start_flag = 1'b1;
                        stop_flag = 1'b0;
                    end
                end
                else begin
                    start_press = '0;
                end
                if (stop_low) begin
                    stop_hold = '0;
                    stop_press++;
                    if (stop_press > PRESS_LIMIT) begin
                        stop_press = '0;
                        stop_flag = 1'b1;
                        start_flag = 1'b0;
                    end
                end
                else begin
                    stop_press = '0;
                end
            end
            else begin
                if (start_low && t.sequence_step == STEP_START) begin
                    single_start_cnt++;
                    if (single_start_cnt > SINGLE_LIMIT) begin
                        single_start_cnt = '0;
                        start_flag = 1'b1;
                        stop_flag = 1'b0;
                    end
                end
                else begin
                    single_start_cnt = '0;
                end
                if (!start_low && t.sequence_step >= STEP_STOP_LO
                        && t.sequence_step <= STEP_STOP_HI) begin
                    single_stop_cnt++;
                    if (single_stop_cnt > SINGLE_LIMIT) begin
                        single_stop_cnt = '0;
                        stop_flag = 1'b1;
                        start_flag = 1'b0;
                    end
                end
                else begin
                    single_stop_cnt = '0;
                end
                if (start_flag) begin
                    single_start_cnt = '0;
                    single_start_hold++;
                    if (single_start_hold > SINGLE_LIMIT) begin
                        single_start_hold = '0;
                        start_flag = 1'b0;
                    end
                end
                if (stop_flag) begin
                    single_stop_cnt = '0;
                    single_stop_hold++;
                    if (single_stop_hold > SINGLE_LIMIT) begin
                        single_stop_hold = '0;
                        stop_flag = 1'b0;
                    end
                end
            end

            if (start_flag) begin
                start_press = '0;
                start_hold++;
                if (start_hold > START_HOLD_LIMIT) begin
                    start_hold = '0;
                    start_flag = 1'b0;
                end
            end
            if (stop_flag) begin
                stop_press = '0;
                stop_hold++;
                if (stop_hold > STOP_HOLD_LIMIT) begin
                    stop_hold = '0;
                    stop_flag = 1'b0;
                end
            end

            // reset slot frozen while its input is disabled
            for (int i = 0; i < NUM_LEVELS; i++) begin
                if (i != LVL_RESET || reset_en) settle_level(i, !t.level_pins[i]);
            end

            if (stop_flag) start_flag = 1'b0;

            rc = level_flag[LVL_RUN];
            ready_src = t.relay_sources[0];
            start_src = t.relay_sources[1];
            alarm_src = t.relay_sources[2];
            trip_src = t.relay_sources[3];
            choice[0] = {open_flag, close_flag, trip_src, alarm_src, rc, start_src, ready_src};
            choice[1] = {open_flag, close_flag, trip_src, rc, start_src, ready_src, alarm_src};
            choice[2] = {open_flag, close_flag, alarm_src, rc, start_src, ready_src, trip_src};
            choice[3] = {open_flag, close_flag, trip_src, alarm_src, start_src, ready_src, rc};
            for (int r = 0; r < NUM_RELAYS; r++) begin
                if (relay_sel[r] != RELAY_HOLD) relay_lv[r] = choice[r][relay_sel[r]];
            end

            if (close_flag) begin
                close_cnt++;
                if (close_cnt > PULSE_LIMIT) begin
                    close_cnt = '0;
                    close_flag = 1'b0;
                end
            end
            if (open_flag) begin
                open_cnt++;
                if (open_cnt > PULSE_LIMIT) begin
                    open_cnt = '0;
                    open_flag = 1'b0;
                end
            end

            want.start_command = start_flag;
            want.stop_command = stop_flag;
            want.ready_level = level_flag[LVL_READY];
            want.run_check_level = level_flag[LVL_RUN];
            want.spare_level = level_flag[LVL_SPARE];
            want.reset_command = level_flag[LVL_RESET];
            want.local_remote_level = level_flag[LVL_LOCAL];
            want.contactor_feedback_level = level_flag[LVL_FEEDBACK];
            want.relay_a = relay_lv[0];
            want.relay_b = relay_lv[1];
            want.relay_c = relay_lv[2];
            want.relay_d = relay_lv[3];
            expected_outputs.push_back(want);
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (want !== got) begin
                $error("%s: expected %0b, got %0b", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_outputs(tick_out_t got);
            tick_out_t want;

            if (expected_outputs.size() == 0) begin
                $error("output item with no input item pending");
                mismatches++;
                return;
            end
            want = expected_outputs.pop_front();
            compare_field("start_command", want.start_command, got.start_command);
            compare_field("stop_command", want.stop_command, got.stop_command);
            compare_field("ready_level", want.ready_level, got.ready_level);
            compare_field("run_check_level", want.run_check_level, got.run_check_level);
            compare_field("spare_level", want.spare_level, got.spare_level);
            compare_field("reset_command", want.reset_command, got.reset_command);
            compare_field("local_remote_level", want.local_remote_level,
                          got.local_remote_level);
            compare_field("contactor_feedback_level", want.contactor_feedback_level,
                          got.contactor_feedback_level);
            compare_field("relay_a", want.relay_a, got.relay_a);
            compare_field("relay_b", want.relay_b, got.relay_b);
            compare_field("relay_c", want.relay_c, got.relay_c);
            compare_field("relay_d", want.relay_d, got.relay_d);
        endfunction

    endclass

endpackage

/* dv/starter_input_qualifier_relay_router_test.sv */
`timescale 1ns / 100ps

module starter_input_qualifier_relay_router_test;

    import siqrr_pkg::*;
    import starter_tick_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          RANDOM_ITEMS_PER_SETTING = 67;
    localparam logic [2:0]  CFG_BEYOND_LO = 3'd6;
    localparam logic [2:0]  CFG_BEYOND_HI = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [2:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       start_pin = 1'b1;
    logic       stop_pin = 1'b1;
    logic       ready_pin = 1'b1;
    logic       run_check_pin = 1'b1;
    logic       spare_pin = 1'b1;
    logic       reset_pin = 1'b1;
    logic       local_remote_pin = 1'b1;
    logic       contactor_feedback_pin = 1'b1;
    logic [7:0] sequence_step = '0;
    logic [3:0] relay_sources = '0;
    logic       close_pulse_request = 1'b0;
    logic       open_pulse_request = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       start_command;
    logic       stop_command;
    logic       ready_level;
    logic       run_check_level;
    logic       spare_level;
    logic       reset_command;
    logic       local_remote_level;
    logic       contactor_feedback_level;
    logic       relay_a;
    logic       relay_b;
    logic       relay_c;
    logic       relay_d;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned cycle_count = 0;
    in_item_t    held_pins;

    starter_tick_scoreboard tick_sb;

    starter_input_qualifier_relay_router dut (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .cfg_we                   (cfg_we),
        .cfg_index                (cfg_index),
        .cfg_data                 (cfg_data),
        .in_valid                 (in_valid),
        .in_stall                 (in_stall),
        .start_pin                (start_pin),
        .stop_pin                 (stop_pin),
        .ready_pin                (ready_pin),
        .run_check_pin            (run_check_pin),
        .spare_pin                (spare_pin),
        .reset_pin                (reset_pin),
        .local_remote_pin         (local_remote_pin),
        .contactor_feedback_pin   (contactor_feedback_pin),
        .sequence_step            (sequence_step),
        .relay_sources            (relay_sources),
        .close_pulse_request      (close_pulse_request),
        .open_pulse_request       (open_pulse_request),
        .out_valid                (out_valid),
        .out_stall                (out_stall),
        .start_command            (start_command),
        .stop_command             (stop_command),
        .ready_level              (ready_level),
        .run_check_level          (run_check_level),
        .spare_level              (spare_level),
        .reset_command            (reset_command),
        .local_remote_level       (local_remote_level),
        .contactor_feedback_level (contactor_feedback_level),
        .relay_a                  (relay_a),
        .relay_b                  (relay_b),
        .relay_c                  (relay_c),
        .relay_d                  (relay_d)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("starter_input_qualifier_relay_router test failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            tick_sb.check_outputs({start_command, stop_command, ready_level, run_check_level,
                                   spare_level, reset_command, local_remote_level,
                                   contactor_feedback_level, relay_a, relay_b, relay_c,
                                   relay_d});
        end
    end

    function automatic in_item_t uniform_item(logic pin, logic [7:0] step, logic [3:0] src,
                                              logic close_req, logic open_req);
        in_item_t it;

        it.start_pin = pin;
        it.stop_pin = pin;
        it.level_pins = {NUM_LEVELS{pin}};
        it.sequence_step = step;
        it.relay_sources = src;
        it.close_pulse_request = close_req;
        it.open_pulse_request = open_req;
        return it;
    endfunction

    // pins held in runs so that debounce and press counters get to fire
    task automatic next_random_item(output in_item_t it);
        int pick;

        if ($urandom_range(0, 13) == 0) held_pins.start_pin = ~held_pins.start_pin;
        if ($urandom_range(0, 13) == 0) held_pins.stop_pin = ~held_pins.stop_pin;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if ($urandom_range(0, 9) == 0) held_pins.level_pins[i] = ~held_pins.level_pins[i];
        end
        if ($urandom_range(0, 9) == 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                held_pins.sequence_step = STEP_START;
            else if (pick < 7)
                held_pins.sequence_step = 8'($urandom_range(STEP_STOP_LO, STEP_STOP_HI));
            else if (pick < 9)
                held_pins.sequence_step = 8'($urandom_range(0, 12));
            else
                held_pins.sequence_step = 8'($urandom_range(0, 255));
        end
        held_pins.relay_sources = 4'($urandom_range(0, 15));
        held_pins.close_pulse_request = ($urandom_range(0, 29) == 0);
        held_pins.open_pulse_request = ($urandom_range(0, 29) == 0);
        it = held_pins;
    endtask

    task automatic send_item(in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        start_pin <= it.start_pin;
        stop_pin <= it.stop_pin;
        ready_pin <= it.level_pins[LVL_READY];
        run_check_pin <= it.level_pins[LVL_RUN];
        spare_pin <= it.level_pins[LVL_SPARE];
        reset_pin <= it.level_pins[LVL_RESET];
        local_remote_pin <= it.level_pins[LVL_LOCAL];
        contactor_feedback_pin <= it.level_pins[LVL_FEEDBACK];
        sequence_step <= it.sequence_step;
        relay_sources <= it.relay_sources;
        close_pulse_request <= it.close_pulse_request;
        open_pulse_request <= it.open_pulse_request;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        tick_sb.accept_tick(it);
        @(negedge clk);
    endtask

    task automatic wait_for_outputs();
        in_valid <= 1'b0;
        while (tick_sb.pending() != 0) @(negedge clk);
    endtask

    task automatic program_registers(logic single, logic reset_en, logic [2:0] sel_a,
                                     logic [2:0] sel_b, logic [2:0] sel_c, logic [2:0] sel_d);
        logic [2:0] idx [7];
        logic [2:0] val [7];

        idx = '{CFG_SINGLE_MODE, CFG_RESET_EN, CFG_RELAY_A, CFG_RELAY_B, CFG_RELAY_C,
                CFG_RELAY_D, CFG_BEYOND_LO};
        if ($urandom_range(0, 1) == 1) idx[6] = CFG_BEYOND_HI;
        val = '{{2'($urandom_range(0, 3)), single}, {2'($urandom_range(0, 3)), reset_en},
                sel_a, sel_b, sel_c, sel_d, 3'($urandom_range(0, 7))};
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            tick_sb.set_register(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        in_item_t it;

        tick_sb = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // everything pressed at once: stop wins, pulse re-requested while active
        program_registers(1'b0, 1'b1, 3'd0, RELAY_HOLD, 3'd6, 3'd5);
        for (int i = 0; i < 12; i++)
            send_item(uniform_item(1'b0, 8'hFF, 4'hF, (i == 0 || i == 4), (i == 0)));
        for (int i = 0; i < 12; i++)
            send_item(uniform_item(1'b1, 8'h00, 4'h0, 1'b0, (i == 11)));

        held_pins = uniform_item(1'b1, 8'h00, 4'h0, 1'b0, 1'b0);
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 38 : (p == 1) ? 53 : 0;
            recv_idle_pct = (p == 0) ? 53 : (p == 1) ? 38 : 0;
            for (int h = 0; h < 2; h++)
            begin
                wait_for_outputs();
                program_registers(((p + h) % 2 == 0), (p == 1),
                                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                repeat (RANDOM_ITEMS_PER_SETTING)
                begin
                    next_random_item(it);
                    send_item(it);
                end
            end
        end

        wait_for_outputs();
        repeat (8) @(negedge clk);
        if (tick_sb.mismatches == 0 && tick_sb.pending() == 0)
            $display("starter_input_qualifier_relay_router test passed");
        else
            $display("starter_input_qualifier_relay_router test failed");
        $finish;
    end

endmodule
